>>> hdl/regression_split_score_core_assert.svh
// Assertion macros for the checker of regression_split_score_core.
`ifndef REGRESSION_SPLIT_SCORE_CORE_ASSERT_SVH
`define REGRESSION_SPLIT_SCORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rss_pkg.sv
`timescale 1ns / 1ps

package rss_pkg;

  // Configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_VALUE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 4'd1;

  // Fixed-point widths and limits
  localparam int WSUM_W = 48;
  localparam int RSUM_W = 64;
  localparam int SCORE_W = 63;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Divider: 128-bit dividend, 48-bit divisor, 64 quotient bits
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [31:0] feature_value;
    logic signed [31:0] response;
    logic [31:0]        weight;
    logic               last_item;
  } rss_in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               split_valid;
  } rss_out_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } rss_div_stat_t;

endpackage

>>> hdl/rss_mul.sv
`timescale 1ns / 1ps

// Shared 32x32 unsigned multiplier, product registered every cycle.
module rss_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= {32'b0, a} * {32'b0, b};
  end

endmodule

>>> hdl/rss_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Caller guarantees dividend[127:64] < divisor, so the remainder fits 48 bits.
module rss_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [127:0]           dividend,
  input  logic [47:0]            divisor,
  output rss_pkg::rss_div_stat_t stat
);
  import rss_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [47:0]          rem_r, rem_nxt;
  logic [63:0]          quo_r, quo_nxt;
  logic [47:0]          dvs_r, dvs_nxt;
  logic [49:0]          diff;
  logic                 ge;

  // trial subtract of the shifted remainder
  assign diff = {1'b0, rem_r, quo_r[63]} - {2'b0, dvs_r};
  assign ge   = ~diff[49];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[111:64];
      quo_nxt  = dividend[63:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[47:0] : {rem_r[46:0], quo_r[63]};
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = quo_r;

endmodule

>>> hdl/regression_split_score_core.sv
`timescale 1ns / 1ps
// A non-last request passes S_IDLE and S_ACC (unweighted) or S_IDLE, S_MUL, S_RND and S_ACC (weighted, via multiplier).
// A last request with both sides non-empty then runs, per side, a 3-pass square on the shared
// multiplier and, unless the term saturates, a bit-serial divide; the score lands in the output register.
// A new request is taken only once the previous one is through: in_ready is high only in S_IDLE.
// Reset (synchronous, active-low rst_n) clears sums, config (cut 0, unweighted) and out_valid.
module regression_split_score_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rss_pkg::rss_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rss_pkg::rss_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_RND, S_ACC, S_CHK, S_ABS, S_SQ0, S_SQ1, S_SQ2, S_SQ3,
    S_DST, S_DWAIT, S_FIN
  } state_t;

  state_t                    state_r, state_nxt;
  rss_in_t                   item_r, item_nxt;
  logic signed [31:0]        cut_r, cut_nxt;
  logic                      wmode_r, wmode_nxt;
  logic signed [RSUM_W-1:0]  lrs_r, lrs_nxt, rrs_r, rrs_nxt;
  logic [WSUM_W-1:0]         lws_r, lws_nxt, rws_r, rws_nxt;
  logic signed [63:0]        wy_r, wy_nxt;
  logic [63:0]               mag_r, mag_nxt;
  logic [127:0]              sq_r, sq_nxt;
  logic                      side_r, side_nxt;
  logic                      valid_r, valid_nxt;
  logic [SCORE_W-1:0]        t1_r, t1_nxt, t2_r, t2_nxt;
  logic                      out_valid_r, out_valid_nxt;
  rss_out_t                  out_data_r, out_data_nxt;

  logic [31:0]               mul_a, mul_b;
  logic [63:0]               prod;
  logic                      div_start;
  rss_div_stat_t             div_stat;

  // combinational helpers
  logic [31:0]               w_eff;
  logic signed [63:0]        wy_eff;
  logic signed [63:0]        s_sel;
  logic [WSUM_W-1:0]         w_sel;
  logic [SCORE_W-1:0]        term;
  logic                      store_term;
  logic [SCORE_W:0]          score_sum;

  function automatic logic signed [63:0] sat_add_s64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic [WSUM_W-1:0] sat_add_w(input logic [WSUM_W-1:0] a,
                                                  input logic [31:0] w);
    logic [WSUM_W:0] s;
    s = {1'b0, a} + {(WSUM_W - 31)'(0), w};
    return s[WSUM_W] ? {WSUM_W{1'b1}} : s[WSUM_W-1:0];
  endfunction

  rss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  rss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sq_r),
    .divisor  (w_sel),
    .stat     (div_stat)
  );

  // multiplier operand select: weighted response, then square partial products
  always_comb begin
    unique case (state_r)
      S_MUL: begin
        mul_a = item_r.response[31] ? (~item_r.response + 32'd1) : item_r.response;
        mul_b = item_r.weight;
      end
      S_SQ0: begin
        mul_a = mag_r[31:0];
        mul_b = mag_r[31:0];
      end
      S_SQ1: begin
        mul_a = mag_r[63:32];
        mul_b = mag_r[31:0];
      end
      S_SQ2: begin
        mul_a = mag_r[63:32];
        mul_b = mag_r[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign w_eff     = wmode_r ? item_r.weight : ONE_Q16;
  assign wy_eff    = wmode_r ? wy_r : 64'(item_r.response);
  assign s_sel     = side_r ? rrs_r : lrs_r;
  assign w_sel     = side_r ? rws_r : lws_r;
  assign score_sum = {1'b0, t1_r} + {1'b0, t2_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cut_nxt       = cut_r;
    wmode_nxt     = wmode_r;
    lrs_nxt       = lrs_r;
    rrs_nxt       = rrs_r;
    lws_nxt       = lws_r;
    rws_nxt       = rws_r;
    wy_nxt        = wy_r;
    mag_nxt       = mag_r;
    sq_nxt        = sq_r;
    side_nxt      = side_r;
    valid_nxt     = valid_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    term          = '0;
    store_term    = 1'b0;

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // register writes
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CUT_VALUE:     cut_nxt = cfg_data;
        REG_WEIGHTED_MODE: wmode_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = wmode_r ? S_MUL : S_ACC;
        end
      end
      S_MUL: state_nxt = S_RND;
      S_RND: begin
        // round to Q16.16, ties toward +inf; negative uses ~p + 1 + 2^15
        if (item_r.response[31]) begin
          wy_nxt = $signed(~prod + 64'h8001) >>> 16;
        end else begin
          wy_nxt = (prod + 64'h8000) >>> 16;
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (item_r.feature_value <= cut_r) begin
          lws_nxt = sat_add_w(lws_r, w_eff);
          lrs_nxt = sat_add_s64(lrs_r, wy_eff);
        end else begin
          rws_nxt = sat_add_w(rws_r, w_eff);
          rrs_nxt = sat_add_s64(rrs_r, wy_eff);
        end
        state_nxt = item_r.last_item ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        valid_nxt = (lws_r != '0) && (rws_r != '0);
        side_nxt  = 1'b0;
        state_nxt = ((lws_r != '0) && (rws_r != '0)) ? S_ABS : S_FIN;
      end
      S_ABS: begin
        mag_nxt   = s_sel[63] ? (~s_sel + 64'd1) : s_sel;
        state_nxt = S_SQ0;
      end
      S_SQ0: state_nxt = S_SQ1;
      S_SQ1: begin
        sq_nxt    = {64'b0, prod};
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        // cross term counted twice
        sq_nxt    = sq_r + {31'b0, prod, 33'b0};
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        sq_nxt    = sq_r + {prod, 64'b0};
        state_nxt = S_DST;
      end
      S_DST: begin
        if (sq_r[127:64] >= {16'b0, w_sel}) begin
          term       = SCORE_MAX;
          store_term = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_stat.done) begin
          term       = div_stat.quot[63] ? SCORE_MAX : div_stat.quot[SCORE_W-1:0];
          store_term = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.split_valid = valid_r;
          if (!valid_r) begin
            out_data_nxt.score = '0;
          end else if (score_sum[SCORE_W]) begin
            out_data_nxt.score = SCORE_MAX;
          end else begin
            out_data_nxt.score = score_sum[SCORE_W-1:0];
          end
          lrs_nxt   = '0;
          rrs_nxt   = '0;
          lws_nxt   = '0;
          rws_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // per-side term done: left moves on to right, right finishes
    if (store_term) begin
      if (!side_r) begin
        t1_nxt    = term;
        side_nxt  = 1'b1;
        state_nxt = S_ABS;
      end else begin
        t2_nxt    = term;
        state_nxt = S_FIN;
      end
    end
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cut_r       <= '0;
      wmode_r     <= 1'b0;
      lrs_r       <= '0;
      rrs_r       <= '0;
      lws_r       <= '0;
      rws_r       <= '0;
      side_r      <= 1'b0;
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cut_r       <= cut_nxt;
      wmode_r     <= wmode_nxt;
      lrs_r       <= lrs_nxt;
      rrs_r       <= rrs_nxt;
      lws_r       <= lws_nxt;
      rws_r       <= rws_nxt;
      side_r      <= side_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    wy_r       <= wy_nxt;
    mag_r      <= mag_nxt;
    sq_r       <= sq_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/rss_checker.sv
`timescale 1ns / 1ps
`include "regression_split_score_core_assert.svh"

// Port-level checks for regression_split_score_core.
module rss_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input rss_pkg::rss_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input rss_pkg::rss_out_t out_data
);
  import rss_pkg::*;

  // stalled result holds
  `RSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // empty side reports zero score
  `RSS_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.split_valid, out_data.score == '0, "invalid split with nonzero score")

  // in_ready drops once a last request is taken
  `RSS_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_data.last_item, !in_ready, "ready right after a last request")

  // a plain request makes no result
  `RSS_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && !in_data.last_item, !$rose(out_valid), "result after a non-last request")

endmodule

bind regression_split_score_core rss_checker u_rss_checker (.*);

>>> sim/regression_split_score_core_test.sv
`timescale 1ns / 1ps

module regression_split_score_core_test;
  import rss_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;
  localparam int SETTLE_CYCLES = 200;
  localparam int STUCK_LIMIT = 3000;
  localparam int PHASE_ITEMS = 185;
  localparam int SAT_ITEMS_PER_SIDE = 24;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic [31:0] W_MAX = 32'hffff_ffff;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rss_in_t in_data;
  logic out_valid;
  logic out_ready;
  rss_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: accumulated sums and register copies
  logic signed [RSUM_W-1:0] left_resp_acc, right_resp_acc;
  logic [WSUM_W-1:0] left_weight_acc, right_weight_acc;
  logic signed [31:0] split_cut;
  logic split_weighted;

  rss_out_t expected_scores[$];
  rss_out_t score_want;
  int unsigned error_count = 0;
  int unsigned scores_checked = 0;
  int unsigned observations_sent = 0;
  int unsigned nodes_closed = 0;
  int unsigned stuck_cycles = 0;
  bit pace_random = 1'b1;

  regression_split_score_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  // response * weight in Q32.32, rounded half up to Q16.16
  function automatic logic signed [63:0] scaled_response(logic signed [31:0] resp,
                                                          logic [31:0] wt);
    logic signed [64:0] rs, ws, prod;
    rs = {{33{resp[31]}}, resp};
    ws = {33'd0, wt};
    prod = (rs * ws + 65'sd32768) >>> 16;
    return prod[63:0];
  endfunction

  function automatic logic signed [63:0] add_resp_sat(logic signed [63:0] acc,
                                                       logic signed [63:0] inc);
    logic [64:0] s;
    s = {acc[63], acc} + {inc[63], inc};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [WSUM_W-1:0] add_weight_sat(logic [WSUM_W-1:0] acc,
                                                        logic [31:0] inc);
    logic [WSUM_W:0] s;
    s = {1'b0, acc} + inc;
    return s[WSUM_W] ? {WSUM_W{1'b1}} : s[WSUM_W-1:0];
  endfunction

  // floor(sum^2 / weight), clamped to the score range
  function automatic logic [63:0] side_term(logic signed [63:0] sum, logic [WSUM_W-1:0] wsum);
    logic [63:0] mag;
    logic [127:0] sq, quo;
    mag = sum[63] ? (~sum + 64'd1) : sum;
    sq = {64'd0, mag} * {64'd0, mag};
    quo = sq / {80'd0, wsum};
    if (quo > {65'd0, SCORE_MAX}) return {1'b0, SCORE_MAX};
    return quo[63:0];
  endfunction

  task automatic clear_sums();
    left_resp_acc = '0;
    right_resp_acc = '0;
    left_weight_acc = '0;
    right_weight_acc = '0;
  endtask

  // Fold one accepted observation into the sums; close the node on last_item
  task automatic absorb_observation(rss_in_t obs);
    logic [31:0] wt;
    logic signed [63:0] contrib;
    logic [63:0] t_left, t_right, total;
    rss_out_t res;
    wt = split_weighted ? obs.weight : ONE_Q16;
    contrib = split_weighted ? scaled_response(obs.response, wt)
                             : {{32{obs.response[31]}}, obs.response};
    if (obs.feature_value <= split_cut) begin
      left_weight_acc = add_weight_sat(left_weight_acc, wt);
      left_resp_acc = add_resp_sat(left_resp_acc, contrib);
    end else begin
      right_weight_acc = add_weight_sat(right_weight_acc, wt);
      right_resp_acc = add_resp_sat(right_resp_acc, contrib);
    end
    if (obs.last_item) begin
      res.split_valid = (left_weight_acc != 0) && (right_weight_acc != 0);
      res.score = '0;
      if (res.split_valid) begin
        t_left = side_term(left_resp_acc, left_weight_acc);
        t_right = side_term(right_resp_acc, right_weight_acc);
        total = t_left + t_right;
        res.score = (total > {1'b0, SCORE_MAX}) ? SCORE_MAX : total[SCORE_W-1:0];
      end
      expected_scores.push_back(res);
      nodes_closed++;
      clear_sums();
    end
  endtask

  // ---------------- checking ----------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_scores.size() == 0) begin
        report_mismatch("score with no node closed", {1'b0, out_data.score}, '0);
      end else begin
        score_want = expected_scores.pop_front();
        if (out_data.score !== score_want.score)
          report_mismatch("score", {1'b0, out_data.score}, {1'b0, score_want.score});
        if (out_data.split_valid !== score_want.split_valid)
          report_mismatch("split_valid", 64'(out_data.split_valid),
                          64'(score_want.split_valid));
        scores_checked++;
      end
    end
  end

  // Watchdog: ends the run when no request moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] watchdog: no request moved for %0d cycles", $time, STUCK_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- pacing ----------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!pace_random) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure: out_ready drops at random while pacing is random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pace_random && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------- drivers ----------------

  task automatic send_observation(rss_in_t obs);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= obs;
    do @(posedge clk); while (!in_ready);
    absorb_observation(obs);
    observations_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CUT_VALUE) split_cut = value;
    else if (idx == REG_WEIGHTED_MODE) split_weighted = value[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every score, then let the block finish any trailing work
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic rss_in_t make_obs(logic signed [31:0] feat, logic signed [31:0] resp,
                                       logic [31:0] wt, logic last);
    rss_in_t obs;
    obs.feature_value = feat;
    obs.response = resp;
    obs.weight = wt;
    obs.last_item = last;
    return obs;
  endfunction

  // Random observation biased toward the cut and the field extremes
  function automatic rss_in_t random_obs(logic last);
    rss_in_t obs;
    case ($urandom_range(0, 9))
      0: obs.feature_value = Q_MIN;
      1: obs.feature_value = Q_MAX;
      2, 3: obs.feature_value = split_cut + $signed($urandom_range(0, 4)) - 2;
      default: obs.feature_value = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0: obs.response = Q_MIN;
      1: obs.response = Q_MAX;
      2: obs.response = '0;
      3, 4: obs.response = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      default: obs.response = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0: obs.weight = '0;
      1: obs.weight = W_MAX;
      2: obs.weight = ONE_Q16;
      3, 4: obs.weight = $urandom_range(0, 32'h3_0000);
      default: obs.weight = $urandom;
    endcase
    obs.last_item = last;
    return obs;
  endfunction

  task automatic send_random_node(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_observation(random_obs(i == len - 1));
  endtask

  // ---------------- tests ----------------

  // Power-up registers: cut at zero, every weight taken as one
  task automatic test_reset_state();
    send_observation(make_obs(32'sd0, 32'sh0002_0000, W_MAX, 1'b0));
    send_observation(make_obs(32'sd1, 32'shfffe_8000, 32'd0, 1'b0));
    send_observation(make_obs(-32'sd1, 32'sh0000_4000, 32'd7, 1'b0));
    send_observation(make_obs(32'sh0001_0000, 32'sh0003_0000, ONE_Q16, 1'b1));
    drain();
  endtask

  task automatic test_directed_cases();
    write_register(REG_WEIGHTED_MODE, 32'd1);
    // single observation: right side stays empty
    send_observation(make_obs(32'sd0, Q_MAX, W_MAX, 1'b1));
    // opposite extremes on both sides
    send_observation(make_obs(Q_MIN, Q_MAX, W_MAX, 1'b0));
    send_observation(make_obs(Q_MAX, Q_MIN, W_MAX, 1'b1));
    // zero weight leaves the left side empty
    send_observation(make_obs(Q_MIN, Q_MAX, 32'd0, 1'b0));
    send_observation(make_obs(32'sd5, 32'sh0001_0000, ONE_Q16, 1'b1));
    // feature at the cut goes left; half-way rounding ties
    send_observation(make_obs(32'sd0, -32'sd1, 32'h0000_8000, 1'b0));
    send_observation(make_obs(32'sd1, 32'sd1, 32'h0000_8000, 1'b0));
    send_observation(make_obs(32'sd1, -32'sd3, 32'h0000_8000, 1'b1));
    // the two terms together overflow the score range
    send_observation(make_obs(32'sd0, Q_MAX, W_MAX, 1'b0));
    send_observation(make_obs(32'sd0, Q_MAX, W_MAX, 1'b0));
    send_observation(make_obs(32'sd9, Q_MIN, W_MAX, 1'b0));
    send_observation(make_obs(32'sd9, Q_MIN, W_MAX, 1'b1));
    drain();
    // unweighted: the weight field is ignored even when zero
    write_register(REG_WEIGHTED_MODE, 32'd0);
    send_observation(make_obs(Q_MIN, Q_MIN, 32'd0, 1'b0));
    send_observation(make_obs(Q_MAX, Q_MAX, 32'd0, 1'b1));
    drain();
  endtask

  task automatic test_register_writes();
    write_register(REG_CUT_VALUE, 32'h0001_0000);
    write_register(REG_WEIGHTED_MODE, 32'd1);
    // an unmapped index must leave both registers alone
    write_register(REG_UNMAPPED, 32'hffff_ffff);
    send_observation(make_obs(32'sh0001_0000, 32'sh0002_0000, 32'h0002_0000, 1'b0));
    send_observation(make_obs(32'sh0001_0001, 32'sh0001_8000, 32'h0000_c000, 1'b0));
    send_observation(make_obs(32'sh0000_ffff, -32'sh0001_0000, ONE_Q16, 1'b1));
    drain();
    write_register(REG_WEIGHTED_MODE, 32'hffff_fffe);
    write_register(REG_CUT_VALUE, 32'hffff_0000);
    send_observation(make_obs(32'shffff_0000, 32'sh0004_0000, 32'h1234_5678, 1'b0));
    send_observation(make_obs(32'shffff_0001, 32'sh0002_0000, 32'h0000_0001, 1'b1));
    drain();
  endtask

  // Random nodes over several register settings, extremes of the cut included
  task automatic test_random_nodes();
    logic [31:0] cuts[6];
    int unsigned sent;
    cuts = '{$urandom, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, $urandom, $urandom};
    for (int phase = 0; phase < 6; phase++) begin
      write_register(REG_CUT_VALUE, cuts[phase]);
      write_register(REG_WEIGHTED_MODE, {31'd0, phase != 1 && phase != 4});
      pace_random = (phase != 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        automatic int unsigned len =
          ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_random_node(len);
        sent += len;
      end
      drain();
    end
    pace_random = 1'b1;
  endtask

  // Long back-to-back node at the field extremes; both terms saturate
  task automatic test_saturating_node();
    write_register(REG_CUT_VALUE, 32'h0000_0000);
    write_register(REG_WEIGHTED_MODE, 32'd1);
    pace_random = 1'b0;
    for (int i = 0; i < 2 * SAT_ITEMS_PER_SIDE; i++) begin
      if (i[0]) send_observation(make_obs(Q_MAX, Q_MIN, W_MAX, i == 2 * SAT_ITEMS_PER_SIDE - 1));
      else send_observation(make_obs(Q_MIN, Q_MAX, W_MAX, 1'b0));
    end
    drain();
    pace_random = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    clear_sums();
    split_cut = '0;
    split_weighted = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_cases();
    test_register_writes();
    test_random_nodes();
    test_saturating_node();

    $display("Ran %0d observations in %0d nodes; %0d scores checked, %0d mismatches",
             observations_sent, nodes_closed, scores_checked, error_count);
    $display("Covered both modes, cut extremes, empty sides, rounding ties and saturation");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
